/* rtl/umie_pkg.sv */
`timescale 1ns / 1ps

package umie_pkg;

  localparam int WORD_BITS      = 32;
  localparam int OP_BITS        = 4;
  localparam int REG_FIELD_BITS = 3;
  localparam int LV_BITS        = 25;
  localparam int NUM_REGISTERS  = 8;

  // Bit positions of the register fields inside an instruction word
  localparam int FIELD_A_LSB  = 6;
  localparam int FIELD_B_LSB  = 3;
  localparam int FIELD_C_LSB  = 0;
  localparam int FIELD_LV_LSB = LV_BITS;

  typedef enum logic [OP_BITS-1:0] {
    OP_CMOV   = 4'd0,
    OP_SLOAD  = 4'd1,
    OP_SSTORE = 4'd2,
    OP_ADD    = 4'd3,
    OP_MUL    = 4'd4,
    OP_DIV    = 4'd5,
    OP_NAND   = 4'd6,
    OP_HALT   = 4'd7,
    OP_MAP    = 4'd8,
    OP_UNMAP  = 4'd9,
    OP_OUT    = 4'd10,
    OP_IN     = 4'd11,
    OP_LOADP  = 4'd12,
    OP_LV     = 4'd13
  } um_op_t;

  typedef enum logic [3:0] {
    REQ_DONE     = 4'd0,
    REQ_OUTPUT   = 4'd1,
    REQ_LOAD     = 4'd2,
    REQ_STORE    = 4'd3,
    REQ_MAP      = 4'd4,
    REQ_UNMAP    = 4'd5,
    REQ_LOADP    = 4'd6,
    REQ_HALT     = 4'd7,
    REQ_ILLEGAL  = 4'd8,
    REQ_PROTOCOL = 4'd9
  } req_kind_t;

  // Item kind on the input channel
  localparam logic ITEM_EXECUTE = 1'b0;
  localparam logic ITEM_DELIVER = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_STORE,
    ST_DIV,
    ST_HOLD
  } state_t;

  typedef struct packed {
    req_kind_t   kind;
    logic [7:0]  obyte;
    logic [31:0] seg;
    logic [31:0] widx;
    logic [31:0] sval;
    logic [31:0] npc;
    logic        fault;
  } result_t;

endpackage

/* rtl/um_instruction_execute.sv */
`timescale 1ns / 1ps

// Execute unit for the 14-opcode Universal Machine.
// Input channel (in_valid/in_ready): one transaction per item. opcode selects
// between executing an instruction word and delivering a returned word
// (loaded memory word or new segment id) to the register that a load or map
// left pending. input_word is the value taken by the input instruction.
// Output channel (out_valid/out_ready): exactly one result transaction per
// item, carrying the request kind and its operands plus the next fetch pc.
// Configuration: cfg_wr_en/cfg_wr_data load the register init value; all
// eight registers read as that value until each is written again.
// Every item passes through ST_EXEC before its result is formed, except
// divide with a nonzero divisor, which goes on through ST_DIV (32 steps of the radix-2
// divider), and store, which goes on through ST_STORE (a third register read on the single
// read port of the first register-file copy).
// Items are taken one at a time: in_ready is high only in ST_IDLE.
// The register file lives in two copies of an 8x32 synchronous RAM, one
// read port each, so two operands come back in the cycle after the address.
// Reset clears the pc, the wait flag and halted state, and marks every
// register as holding the init value (0 after reset); no clearing pass.
// A result that the receiver stalls waits in the output register; the next
// input transaction is still taken, and its result holds until room frees.

module um_instruction_execute #(
  parameter int NUM_REGISTERS = umie_pkg::NUM_REGISTERS
) (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  // input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        opcode,
  input  logic [31:0] instruction,
  input  logic [31:0] return_word,
  input  logic [31:0] input_word,
  // output channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  request_kind,
  output logic [7:0]  out_byte,
  output logic [31:0] segment_id,
  output logic [31:0] word_index,
  output logic [31:0] store_value,
  output logic [31:0] next_pc,
  output logic        divide_fault
);

  import umie_pkg::*;

  localparam int AW = $clog2(NUM_REGISTERS);

  // ---------------------------------------------------------------------------
  // Control and architectural state
  // ---------------------------------------------------------------------------
  state_t state, state_next;

  logic [31:0]   pc, pc_next;
  logic [AW-1:0] pend, pend_next;
  logic          awaiting, awaiting_next;
  logic          halted, halted_next;

  // register init value and per-register "written since init" flags
  logic [31:0]              reg_init;
  logic [NUM_REGISTERS-1:0] vld;

  // captured transaction
  logic        opc_q;
  logic [31:0] ins_q;
  logic [31:0] ret_q;
  logic [31:0] inw_q;

  // operands held for the store's third read
  logic [31:0] rb_q;
  logic [31:0] rc_q;

  // iterative divider
  logic [31:0] div_rem;
  logic [31:0] div_quo;
  logic [31:0] div_dvs;
  logic [4:0]  div_cnt;

  result_t held;

  // ---------------------------------------------------------------------------
  // Register file: two RAM copies written together
  // ---------------------------------------------------------------------------
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [31:0]   wr_data;
  logic [AW-1:0] rd1_addr;
  logic [AW-1:0] rd2_addr;
  logic [31:0]   ram1_q;
  logic [31:0]   ram2_q;

  umie_ram #(
    .WIDTH (32),
    .DEPTH (NUM_REGISTERS)
  ) u_ram1 (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .raddr (rd1_addr),
    .rdata (ram1_q)
  );

  umie_ram #(
    .WIDTH (32),
    .DEPTH (NUM_REGISTERS)
  ) u_ram2 (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .raddr (rd2_addr),
    .rdata (ram2_q)
  );

  // Instruction fields of the captured word
  logic [AW-1:0] fa, fb, fc, flv;
  um_op_t        op;

  assign fa  = ins_q[FIELD_A_LSB +: AW];
  assign fb  = ins_q[FIELD_B_LSB +: AW];
  assign fc  = ins_q[FIELD_C_LSB +: AW];
  assign flv = ins_q[FIELD_LV_LSB +: AW];
  assign op  = um_op_t'(ins_q[WORD_BITS-1 -: OP_BITS]);

  // Issue B and C reads straight from the incoming word while idle; the store
  // reuses the first port for A in the next cycle.
  assign rd1_addr = (state == ST_EXEC) ? fa : instruction[FIELD_B_LSB +: AW];
  assign rd2_addr = instruction[FIELD_C_LSB +: AW];

  // Registers not written since the last init read as the init value
  logic [31:0] rb, rc, ra;

  assign rb = vld[fb] ? ram1_q : reg_init;
  assign rc = vld[fc] ? ram2_q : reg_init;
  assign ra = vld[fa] ? ram1_q : reg_init;

  logic [31:0] prod;
  assign prod = rb * rc;

  // ---------------------------------------------------------------------------
  // Divider step: restoring, one quotient bit per cycle
  // ---------------------------------------------------------------------------
  logic [32:0] rem_sh;
  logic        div_ge;
  logic [31:0] rem_diff;
  logic [31:0] rem_step;
  logic [31:0] quo_step;
  logic        div_last;

  assign rem_sh   = {div_rem, div_quo[31]};
  assign div_ge   = rem_sh >= {1'b0, div_dvs};
  assign rem_diff = rem_sh[31:0] - div_dvs;
  assign rem_step = div_ge ? rem_diff : rem_sh[31:0];
  assign quo_step = {div_quo[30:0], div_ge};
  assign div_last = (div_cnt == 5'd31);

  // ---------------------------------------------------------------------------
  // Datapath: decode, execute and result formation
  // ---------------------------------------------------------------------------
  result_t fin;
  logic    fin_valid;
  logic    to_div;
  logic    to_store;

  always_comb begin
    fin           = '0;
    fin.kind      = REQ_DONE;
    fin_valid     = 1'b0;
    to_div        = 1'b0;
    to_store      = 1'b0;
    wr_en         = 1'b0;
    wr_addr       = fa;
    wr_data       = rb;
    pc_next       = pc;
    pend_next     = pend;
    awaiting_next = awaiting;
    halted_next   = halted;

    unique case (state)
      ST_EXEC: begin
        fin_valid = 1'b1;
        if (halted) begin
          fin.kind = REQ_HALT;
        end else if (opc_q == ITEM_DELIVER) begin
          if (awaiting) begin
            wr_en         = 1'b1;
            wr_addr       = pend;
            wr_data       = ret_q;
            awaiting_next = 1'b0;
          end else begin
            fin.kind = REQ_PROTOCOL;
          end
        end else if (awaiting) begin
          fin.kind = REQ_PROTOCOL;
        end else begin
          pc_next = pc + 32'd1;
          unique case (op)
            OP_CMOV: begin
              wr_en = (rc != 32'd0);
            end
            OP_SLOAD: begin
              fin.kind      = REQ_LOAD;
              fin.seg       = rb;
              fin.widx      = rc;
              pend_next     = fa;
              awaiting_next = 1'b1;
            end
            OP_SSTORE: begin
              // A arrives next cycle on the first read port
              fin_valid = 1'b0;
              to_store  = 1'b1;
            end
            OP_ADD: begin
              wr_en   = 1'b1;
              wr_data = rb + rc;
            end
            OP_MUL: begin
              wr_en   = 1'b1;
              wr_data = prod;
            end
            OP_DIV: begin
              if (rc == 32'd0) begin
                wr_en     = 1'b1;
                wr_data   = '1;
                fin.fault = 1'b1;
              end else begin
                fin_valid = 1'b0;
                to_div    = 1'b1;
              end
            end
            OP_NAND: begin
              wr_en   = 1'b1;
              wr_data = ~(rb & rc);
            end
            OP_HALT: begin
              fin.kind    = REQ_HALT;
              halted_next = 1'b1;
              pc_next     = pc;
            end
            OP_MAP: begin
              fin.kind      = REQ_MAP;
              fin.sval      = rc;
              pend_next     = fb;
              awaiting_next = 1'b1;
            end
            OP_UNMAP: begin
              fin.kind = REQ_UNMAP;
              fin.seg  = rc;
            end
            OP_OUT: begin
              fin.kind  = REQ_OUTPUT;
              fin.obyte = rc[7:0];
            end
            OP_IN: begin
              wr_en   = 1'b1;
              wr_addr = fc;
              wr_data = inw_q;
            end
            OP_LOADP: begin
              fin.kind = REQ_LOADP;
              fin.seg  = rb;
              pc_next  = rc;
            end
            OP_LV: begin
              wr_en   = 1'b1;
              wr_addr = flv;
              wr_data = {{(WORD_BITS-LV_BITS){1'b0}},
                         ins_q[LV_BITS-1:0]};
            end
            default: begin
              fin.kind    = REQ_ILLEGAL;
              halted_next = 1'b1;
              pc_next     = pc;
            end
          endcase
        end
      end
      ST_STORE: begin
        fin_valid = 1'b1;
        fin.kind  = REQ_STORE;
        fin.seg   = ra;
        fin.widx  = rb_q;
        fin.sval  = rc_q;
      end
      ST_DIV: begin
        if (div_last) begin
          fin_valid = 1'b1;
          wr_en     = 1'b1;
          wr_data   = quo_step;
        end
      end
      ST_IDLE, ST_HOLD: begin
      end
      default: begin
      end
    endcase

    fin.npc = pc_next;
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  logic out_free;
  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (to_div) begin
          state_next = ST_DIV;
        end else if (to_store) begin
          state_next = ST_STORE;
        end else begin
          state_next = out_free ? ST_IDLE : ST_HOLD;
        end
      end
      ST_STORE: begin
        state_next = out_free ? ST_IDLE : ST_HOLD;
      end
      ST_DIV: begin
        if (div_last) begin
          state_next = out_free ? ST_IDLE : ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  logic out_load_fin;
  logic out_load_held;
  logic held_load;

  always_comb begin
    in_ready      = 1'b0;
    out_load_fin  = 1'b0;
    out_load_held = 1'b0;
    held_load     = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
      end
      ST_EXEC, ST_STORE, ST_DIV: begin
        out_load_fin = fin_valid && out_free;
        held_load    = fin_valid && !out_free;
      end
      ST_HOLD: begin
        out_load_held = out_free;
      end
      default: begin
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      pc       <= '0;
      pend     <= '0;
      awaiting <= 1'b0;
      halted   <= 1'b0;
      reg_init <= '0;
      vld      <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_EXEC) begin
        pc       <= pc_next;
        pend     <= pend_next;
        awaiting <= awaiting_next;
        halted   <= halted_next;
      end
      // a config write re-inits every register; write it only while idle (not enforced here)
      if (cfg_wr_en) begin
        reg_init <= cfg_wr_data;
        vld      <= '0;
      end else if (wr_en) begin
        vld[wr_addr] <= 1'b1;
      end
      if (out_load_fin || out_load_held) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      opc_q <= opcode;
      ins_q <= instruction;
      ret_q <= return_word;
      inw_q <= input_word;
    end
    if (state == ST_EXEC) begin
      rb_q <= rb;
      rc_q <= rc;
    end
    // load the divider on entry, then shift one quotient bit per cycle
    if (to_div) begin
      div_rem <= '0;
      div_quo <= rb;
      div_dvs <= rc;
      div_cnt <= '0;
    end else if (state == ST_DIV) begin
      div_rem <= rem_step;
      div_quo <= quo_step;
      div_cnt <= div_cnt + 5'd1;
    end
    if (held_load) begin
      held <= fin;
    end
    if (out_load_fin) begin
      request_kind <= 4'(fin.kind);
      out_byte     <= fin.obyte;
      segment_id   <= fin.seg;
      word_index   <= fin.widx;
      store_value  <= fin.sval;
      next_pc      <= fin.npc;
      divide_fault <= fin.fault;
    end else if (out_load_held) begin
      request_kind <= 4'(held.kind);
      out_byte     <= held.obyte;
      segment_id   <= held.seg;
      word_index   <= held.widx;
      store_value  <= held.sval;
      next_pc      <= held.npc;
      divide_fault <= held.fault;
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_hold_means_busy: assert property (@(posedge clk) disable iff (rst)
    (state == ST_HOLD) |-> out_valid)
    else $error("result held while output register is empty");

  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE || state == ST_HOLD) |-> !wr_en)
    else $error("register file written with no item at work");

  a_halt_sticks: assert property (@(posedge clk) disable iff (rst)
    halted |=> halted)
    else $error("halted state cleared without reset");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second transaction accepted while an item is at work");

endmodule

/* rtl/umie_ram.sv */
`timescale 1ns / 1ps

module umie_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
